// File: design/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // item opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;       // latch the incoming item
        logic    write_result;  // load the result register
        logic    do_insert;     // shift cells and place the value
        logic    do_remove;     // shift cells toward the head
        status_t code;          // status reported with the result
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// File: design/sorted_priority_queue_unit.sv
// sorted priority queue
//
// input channel (s_valid / s_ready): s_op selects insert (OP_INSERT) or
// remove of the largest value (OP_REMOVE); s_value is the signed value to
// insert and is ignored on remove
// result channel (m_valid / m_ready): one result item per input item with
// m_status (ok, overflow, underflow), m_removed_value (the largest value
// on a good remove, else 0) and m_fill_count (entries held afterwards)
//
// values sit in a row of CAPACITY cells, largest at the head; all cells
// compare and shift at once, so any insert or remove completes in the
// execute state after the item is latched
// result path: the item is latched on acceptance as the controller moves
// to ST_EXEC, which loads the result register and sets m_valid
// items are taken one at a time, none while the controller is in ST_EXEC
// of its latch/execute sequence; among equal values the newest leaves first
// reset clears the entry count and the result valid; cell contents are
// left as they are and never read beyond the count
// a stalled result holds in the output register; one further item is not
// taken until that register is taken or drains in the same cycle
module sorted_priority_queue_unit #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(CAPACITY + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [VALUE_WIDTH-1:0] m_removed_value,
    output logic [CW-1:0]                 m_fill_count
);
    import spq_pkg::*;

    // command and status between controller and cell row
    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CW          (CW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_value         (s_value),
        .cmd             (cmd),
        .stat            (stat),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_fill_count    (m_fill_count)
    );

endmodule

// File: design/spq_ctrl.sv
module spq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.code         = STATUS_OK;
        unique case (state_reg)
            ST_IDLE: begin
                // result register frees up when taken this cycle
                s_ready = !m_valid_reg || m_ready;
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.write_result = 1'b1;
                m_valid_next     = 1'b1;
                state_next       = ST_IDLE;
                if (stat.op_remove) begin
                    if (stat.empty) begin
                        cmd.code = STATUS_UNDERFLOW;
                    end else begin
                        cmd.do_remove = 1'b1;
                    end
                end else begin
                    if (stat.full) begin
                        cmd.code = STATUS_OVERFLOW;
                    end else begin
                        cmd.do_insert = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: design/spq_datapath.sv
module spq_datapath #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(CAPACITY + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_op,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  spq_pkg::spq_cmd_t             cmd,
    output spq_pkg::spq_stat_t            stat,
    output logic [1:0]                    m_status,
    output logic signed [VALUE_WIDTH-1:0] m_removed_value,
    output logic [CW-1:0]                 m_fill_count
);
    import spq_pkg::*;

    logic                          op_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] entry_reg [CAPACITY];
    logic [CAPACITY-1:0]           at_or_after;
    logic [1:0]                    status_reg;
    logic signed [VALUE_WIDTH-1:0] removed_reg;
    logic [CW-1:0]                 fill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.do_insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.do_remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    // each cell compares against the new value; the sorted order makes
    // at_or_after a thermometer code that marks the insert point
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            assign at_or_after[i] = (count_reg <= CW'(i)) || (value_reg >= entry_reg[i]);

            if (i == 0) begin : g_head
                always_ff @(posedge aclk) begin
                    if (cmd.do_insert && at_or_after[0]) begin
                        entry_reg[0] <= value_reg;
                    end else if (cmd.do_remove) begin
                        entry_reg[0] <= entry_reg[1];
                    end
                end
            end else if (i == CAPACITY - 1) begin : g_tail
                always_ff @(posedge aclk) begin
                    if (cmd.do_insert && at_or_after[i]) begin
                        entry_reg[i] <= at_or_after[i-1] ? entry_reg[i-1] : value_reg;
                    end
                end
            end else begin : g_mid
                always_ff @(posedge aclk) begin
                    if (cmd.do_insert && at_or_after[i]) begin
                        entry_reg[i] <= at_or_after[i-1] ? entry_reg[i-1] : value_reg;
                    end else if (cmd.do_remove) begin
                        entry_reg[i] <= entry_reg[i+1];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.write_result) begin
            status_reg  <= cmd.code;
            removed_reg <= cmd.do_remove ? entry_reg[0] : '0;
            fill_reg    <= count_next;
        end
    end

    assign stat.op_remove  = (op_reg == OP_REMOVE);
    assign stat.full       = (count_reg >= CW'(CAPACITY));
    assign stat.empty      = (count_reg == '0);

    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_fill_count    = fill_reg;

endmodule

// File: design/spq_checker.sv
module spq_checker #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(CAPACITY + 1)
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_status,
    input logic [VALUE_WIDTH-1:0] m_removed_value,
    input logic [CW-1:0]          m_fill_count
);
    import spq_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_removed_value) && $stable(m_fill_count))
        else $error("stalled result changed");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous still executing");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STATUS_OK || m_status == STATUS_OVERFLOW
            || m_status == STATUS_UNDERFLOW)
        else $error("illegal status code");

    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_removed_value == '0)
        else $error("removed value not zero on error");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fill_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW)
) u_spq_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_removed_value (m_removed_value),
    .m_fill_count    (m_fill_count)
);
